/* rtl/fpalu_pkg.sv */
package fpalu_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int QUO_WIDTH  = WORD_WIDTH + FRAC_BITS;
    localparam int PACK_WIDTH = 2 * WORD_WIDTH + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [WORD_WIDTH-1:0]        mag_t;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV,
        CLS_DIV_ZERO
    } class_t;

    typedef struct packed {
        opcode_t op;
        class_t  cls;
        word_t   a;
        word_t   b;
        mag_t    ma;
        mag_t    mb;
        logic    neg;
    } entry_t;

    typedef struct packed {
        word_t value;
        logic  ovf;
    } packed_t;

    function automatic packed_t pack_word(input logic neg, input logic [PACK_WIDTH-1:0] mag);
        logic [PACK_WIDTH-1:0] lim;
        logic [PACK_WIDTH-1:0] m;
        packed_t               r;
        lim = {{(PACK_WIDTH-WORD_WIDTH){1'b0}}, 1'b1, {(WORD_WIDTH-1){1'b0}}};
        if (!neg)
        begin
            lim = lim - 1'b1;
        end
        r.ovf = (mag > lim);
        m = r.ovf ? lim : mag;
        r.value = neg ? word_t'(~m[WORD_WIDTH-1:0] + 1'b1) : word_t'(m[WORD_WIDTH-1:0]);
        return r;
    endfunction

endpackage

/* rtl/fpalu_if.sv */
interface fpalu_in_if;
    logic                    valid;
    logic                    ready;
    logic [3:0]              opcode;
    fpalu_pkg::word_t        operand_a;
    fpalu_pkg::word_t        operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpalu_out_if;
    logic                    valid;
    logic                    ready;
    fpalu_pkg::word_t        result_value;
    logic                    compare_true;
    logic                    overflow;
    logic                    divide_by_zero;

    modport source (output valid, output result_value, output compare_true,
                    output overflow, output divide_by_zero, input ready);
    modport sink   (input valid, input result_value, input compare_true,
                    input overflow, input divide_by_zero, output ready);
endinterface

/* rtl/fpalu_front.sv */
module fpalu_front (
    fpalu_in_if.sink          in,
    input  logic              full,
    output logic              push,
    output fpalu_pkg::entry_t entry
);

    fpalu_pkg::opcode_t op;

    assign op       = fpalu_pkg::opcode_t'(in.opcode);
    assign in.ready = !full;
    assign push     = in.valid && !full;

    always_comb
    begin
        entry.op  = op;
        entry.a   = in.operand_a;
        entry.b   = in.operand_b;
        entry.ma  = in.operand_a[fpalu_pkg::WORD_WIDTH-1] ?
                    fpalu_pkg::mag_t'(~in.operand_a + 1'b1) : fpalu_pkg::mag_t'(in.operand_a);
        entry.mb  = in.operand_b[fpalu_pkg::WORD_WIDTH-1] ?
                    fpalu_pkg::mag_t'(~in.operand_b + 1'b1) : fpalu_pkg::mag_t'(in.operand_b);
        entry.neg = in.operand_a[fpalu_pkg::WORD_WIDTH-1] ^ in.operand_b[fpalu_pkg::WORD_WIDTH-1];
        unique case (op)
            fpalu_pkg::OP_MUL: entry.cls = fpalu_pkg::CLS_MUL;
            fpalu_pkg::OP_DIV: entry.cls = (in.operand_b == '0) ?
                                           fpalu_pkg::CLS_DIV_ZERO : fpalu_pkg::CLS_DIV;
            default:           entry.cls = fpalu_pkg::CLS_SIMPLE;
        endcase
    end

endmodule

/* rtl/fpalu_queue.sv */
module fpalu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fpalu_pkg::entry_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output fpalu_pkg::entry_t head
);

    fpalu_pkg::entry_t                     mem_reg [fpalu_pkg::QUEUE_DEPTH];
    logic [fpalu_pkg::QPTR_WIDTH-1:0]      wr_ptr_reg;
    logic [fpalu_pkg::QPTR_WIDTH-1:0]      rd_ptr_reg;
    logic [fpalu_pkg::QPTR_WIDTH:0]        count_reg;
    logic [fpalu_pkg::QPTR_WIDTH:0]        count_next;
    logic                                  do_pop;

    assign full   = (count_reg == (fpalu_pkg::QPTR_WIDTH+1)'(fpalu_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/fpalu_back.sv */
module fpalu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  fpalu_pkg::entry_t head,
    output logic              pop,
    fpalu_out_if.source       out
);

    localparam int W  = fpalu_pkg::WORD_WIDTH;
    localparam int F  = fpalu_pkg::FRAC_BITS;
    localparam int QW = fpalu_pkg::QUO_WIDTH;
    localparam int PW = fpalu_pkg::PACK_WIDTH;

    typedef struct packed {
        fpalu_pkg::class_t   cls;
        logic                neg;
        fpalu_pkg::word_t    val;
        logic                cmp;
        logic                ovf;
        logic [2*W-1:0]      prod;
        logic [QW-1:0]       num;
        logic [QW-1:0]       quo;
        logic [W-1:0]        rem;
        fpalu_pkg::mag_t     d;
    } stage_t;

    stage_t           st_reg [QW+1];
    logic [QW:0]      st_valid_reg;
    stage_t           s0;
    logic             adv;
    logic             fin_valid_reg;
    fpalu_pkg::word_t fin_val_reg;
    logic             fin_cmp_reg;
    logic             fin_ovf_reg;
    logic             fin_dz_reg;
    fpalu_pkg::packed_t fin_pack;
    fpalu_pkg::word_t fin_val;
    logic             fin_ovf;

    function automatic stage_t div_step(input stage_t s);
        stage_t     r;
        logic [W:0] rem2;
        r    = s;
        rem2 = {s.rem, s.num[QW-1]};
        r.num = {s.num[QW-2:0], 1'b0};
        if (rem2 >= {1'b0, s.d})
        begin
            rem2  = rem2 - {1'b0, s.d};
            r.quo = {s.quo[QW-2:0], 1'b1};
        end
        else
        begin
            r.quo = {s.quo[QW-2:0], 1'b0};
        end
        r.rem = rem2[W-1:0];
        return r;
    endfunction

    assign adv = !fin_valid_reg || out.ready;
    assign pop = adv;

    always_comb
    begin
        logic [W:0] sum;
        logic [W:0] rhs;
        logic       sub;
        s0       = '0;
        s0.cls   = head.cls;
        s0.neg   = head.neg;
        s0.prod  = head.ma * head.mb;
        s0.num   = {head.ma, {F{1'b0}}};
        s0.d     = head.mb;
        sub      = (head.op == fpalu_pkg::OP_SUB) || (head.op == fpalu_pkg::OP_DEC);
        rhs      = ((head.op == fpalu_pkg::OP_INC) || (head.op == fpalu_pkg::OP_DEC)) ?
                   (W+1)'(1) : {head.b[W-1], head.b};
        sum      = sub ? ({head.a[W-1], head.a} - rhs) : ({head.a[W-1], head.a} + rhs);
        case (head.op)
            fpalu_pkg::OP_ADD, fpalu_pkg::OP_SUB, fpalu_pkg::OP_INC, fpalu_pkg::OP_DEC:
            begin
                s0.ovf = sum[W] ^ sum[W-1];
                if (s0.ovf)
                begin
                    s0.val = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    s0.val = sum[W-1:0];
                end
            end
            fpalu_pkg::OP_GT: s0.cmp = head.a >  head.b;
            fpalu_pkg::OP_LT: s0.cmp = head.a <  head.b;
            fpalu_pkg::OP_GE: s0.cmp = head.a >= head.b;
            fpalu_pkg::OP_LE: s0.cmp = head.a <= head.b;
            fpalu_pkg::OP_EQ: s0.cmp = head.a == head.b;
            fpalu_pkg::OP_NE: s0.cmp = head.a != head.b;
            fpalu_pkg::OP_MIN: s0.val = (head.a < head.b) ? head.a : head.b;
            fpalu_pkg::OP_MAX: s0.val = (head.a > head.b) ? head.a : head.b;
            fpalu_pkg::OP_TO_INT:
            begin
                s0.val = head.a[W-1] ? fpalu_pkg::word_t'(~(head.ma >> F) + 1'b1) :
                                       fpalu_pkg::word_t'(head.ma >> F);
            end
            fpalu_pkg::OP_FROM_INT:
            begin
                {s0.val, s0.ovf} = fpalu_pkg::pack_word(head.a[W-1],
                                       PW'({head.ma, {F{1'b0}}}));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        logic [PW-1:0] rsum;
        logic [QW:0]   q1;
        logic [W-1:0]  diff;
        fin_pack = '0;
        fin_val  = st_reg[QW].val;
        fin_ovf  = st_reg[QW].ovf;
        rsum     = PW'({1'b0, st_reg[QW].prod}) + PW'(1 << (F - 1));
        diff     = st_reg[QW].d - st_reg[QW].rem;
        q1       = {1'b0, st_reg[QW].quo} + (QW+1)'(st_reg[QW].rem >= diff);
        case (st_reg[QW].cls)
            fpalu_pkg::CLS_MUL:
            begin
                fin_pack = fpalu_pkg::pack_word(st_reg[QW].neg, rsum >> F);
                fin_val  = fin_pack.value;
                fin_ovf  = fin_pack.ovf;
            end
            fpalu_pkg::CLS_DIV:
            begin
                fin_pack = fpalu_pkg::pack_word(st_reg[QW].neg, PW'(q1));
                fin_val  = fin_pack.value;
                fin_ovf  = fin_pack.ovf;
            end
            fpalu_pkg::CLS_DIV_ZERO:
            begin
                fin_val = '0;
                fin_ovf = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg  <= {st_valid_reg[QW-1:0], !empty};
            fin_valid_reg <= st_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= s0;
            for (int i = 1; i <= QW; i++)
            begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
            fin_val_reg <= fin_val;
            fin_cmp_reg <= st_reg[QW].cmp;
            fin_ovf_reg <= fin_ovf;
            fin_dz_reg  <= (st_reg[QW].cls == fpalu_pkg::CLS_DIV_ZERO);
        end
    end

    assign out.valid          = fin_valid_reg;
    assign out.result_value   = fin_val_reg;
    assign out.compare_true   = fin_cmp_reg;
    assign out.overflow       = fin_ovf_reg;
    assign out.divide_by_zero = fin_dz_reg;

endmodule

/* rtl/fixed_point_alu_q24_8.sv */
// Signed Q24.8 fixed-point ALU.
// Channel in: opcode, operand_a, operand_b, taken when valid and ready are high.
// Channel out: result_value, compare_true, overflow, divide_by_zero, one per request.
// A front stage decodes the opcode, takes operand magnitudes and pushes the
// request into a four-entry queue; in.ready is low only while the queue is full.
// The back pipeline pops one request per cycle unless held: one stage for the
// multiplier and simple ops, forty restoring divider stages (one quotient bit
// each, word width plus fraction bits), and one rounding and saturation stage
// that drives the output register.
// Throughput: one request per cycle, every opcode, while the pipeline is not held.
// Every opcode passes through the same stages, so results leave in request order.
// When out.valid is high and out.ready is low the whole back pipeline holds; the
// queue absorbs up to four more requests before in.ready drops.
// Reset clears the queue and all valid bits; no request is in flight after it.
module fixed_point_alu_q24_8 (
    input  logic        clk,
    input  logic        rst_n,
    fpalu_in_if.sink    in,
    fpalu_out_if.source out
);

    fpalu_pkg::entry_t entry;
    fpalu_pkg::entry_t head;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;

    fpalu_front u_front (
        .in    (in),
        .full  (full),
        .push  (push),
        .entry (entry)
    );

    fpalu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    fpalu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .out   (out)
    );

endmodule

/* rtl/fpalu_checker.sv */
module fpalu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input fpalu_pkg::word_t result_value,
    input logic             compare_true,
    input logic             overflow,
    input logic             divide_by_zero
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result dropped or changed while stalled");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> result_value == '0 && !overflow)
        else $error("comparison carries a value or overflow");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_value == '0 && !overflow && !compare_true)
        else $error("divide by zero result malformed");

    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            result_value == {1'b1, {(fpalu_pkg::WORD_WIDTH-1){1'b0}}} ||
            result_value == {1'b0, {(fpalu_pkg::WORD_WIDTH-1){1'b1}}})
        else $error("overflow without saturated value");

endmodule

bind fixed_point_alu_q24_8 fpalu_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out.valid),
    .out_ready      (out.ready),
    .result_value   (out.result_value),
    .compare_true   (out.compare_true),
    .overflow       (out.overflow),
    .divide_by_zero (out.divide_by_zero)
);
